FILE: rtl/core/bracket_nesting_checker_defines.svh
// Assertion helpers for the core RTL.
// Each use expects clk and rst_n in scope.
`ifndef BRACKET_NESTING_CHECKER_DEFINES_SVH
`define BRACKET_NESTING_CHECKER_DEFINES_SVH

// Same-cycle implication.
`define BNC_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BNC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bnc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bnc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
  localparam int MEM_ENTRIES = 1 << ADDR_W;

  // Bracket kind codes on the stack.
  localparam logic [2:0] CODE_NONE  = 3'd0;
  localparam logic [2:0] CODE_PAREN = 3'd1;
  localparam logic [2:0] CODE_SQUARE = 3'd2;
  localparam logic [2:0] CODE_CURLY = 3'd3;
  localparam logic [2:0] CODE_ANGLE = 3'd4;

  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LCURLY  = 8'h7B;
  localparam logic [7:0] CH_RCURLY  = 8'h7D;
  localparam logic [7:0] CH_LANGLE  = 8'h3C;
  localparam logic [7:0] CH_RANGLE  = 8'h3E;

  localparam logic [14:0] PTS_PAREN  = 15'd3;
  localparam logic [14:0] PTS_SQUARE = 15'd57;
  localparam logic [14:0] PTS_CURLY  = 15'd1197;
  localparam logic [14:0] PTS_ANGLE  = 15'd25137;

  typedef enum logic [1:0] {
    ST_BALANCED   = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_CORRUPT    = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  // Classified word handed from front to back.
  typedef struct packed {
    logic [7:0] char_byte;
    logic [2:0] open_code;
    logic [2:0] close_code;
    logic       line_end;
  } item_t;

  // One stack entry: bracket code and 5^position mod 2^64.
  typedef struct packed {
    logic [63:0] pow;
    logic [2:0]  code;
  } entry_t;

  // Packed so the first field sits in the highest bits.
  typedef struct packed {
    logic [6:0]  open_depth;
    logic [63:0] completion_points;
    logic [14:0] error_points;
    logic [7:0]  bad_byte;
    status_t     line_status;
  } result_t;

  function automatic logic [2:0] opener_code(input logic [7:0] b);
    logic [2:0] c;
    unique case (b)
      CH_LPAREN:  c = CODE_PAREN;
      CH_LSQUARE: c = CODE_SQUARE;
      CH_LCURLY:  c = CODE_CURLY;
      CH_LANGLE:  c = CODE_ANGLE;
      default:    c = CODE_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] closer_code(input logic [7:0] b);
    logic [2:0] c;
    unique case (b)
      CH_RPAREN:  c = CODE_PAREN;
      CH_RSQUARE: c = CODE_SQUARE;
      CH_RCURLY:  c = CODE_CURLY;
      CH_RANGLE:  c = CODE_ANGLE;
      default:    c = CODE_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [14:0] error_score(input logic [7:0] b);
    logic [14:0] s;
    unique case (b)
      CH_RPAREN:  s = PTS_PAREN;
      CH_RSQUARE: s = PTS_SQUARE;
      CH_RCURLY:  s = PTS_CURLY;
      CH_RANGLE:  s = PTS_ANGLE;
      default:    s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bnc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bnc_front (
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [7:0]    in_tdata,   // [7:0] char_byte
  input  wire logic          in_tlast,   // line_end
  output logic               q_push,
  output bnc_pkg::item_t     q_item,
  input  wire logic          q_ready
);
  import bnc_pkg::*;

  // Decode the byte once here so the back end matches brackets by code.
  always_comb begin
    q_item.char_byte  = in_tdata;
    q_item.open_code  = opener_code(in_tdata);
    q_item.close_code = closer_code(in_tdata);
    q_item.line_end   = in_tlast;
  end

  assign in_tready = q_ready;
  assign q_push    = in_tvalid & q_ready;

endmodule

`default_nettype wire

FILE: rtl/core/bnc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bnc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire bnc_pkg::item_t wr_item,
  output logic                wr_ready,
  output logic                rd_valid,
  output bnc_pkg::item_t      rd_item,
  input  wire logic           rd_en
);
  import bnc_pkg::*;

  item_t       slot_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        wr_ptr_nxt;
  logic        rd_ptr_nxt;
  logic [1:0]  count_nxt;
  logic        do_wr;
  logic        do_rd;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_item  = slot_r[rd_ptr_r];
  assign do_wr    = wr_en & wr_ready;
  assign do_rd    = rd_en & rd_valid;

  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bnc_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "bracket_nesting_checker_defines.svh"

module bnc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire bnc_pkg::item_t q_item,
  output logic                q_take,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output bnc_pkg::result_t    out_result
);
  import bnc_pkg::*;

  // Stack storage; top two entries live in top_r / sec_r, rd_r prefetches the third.
  entry_t             mem [MEM_ENTRIES];
  entry_t             top_r, top_nxt;
  entry_t             sec_r, sec_nxt;
  entry_t             rd_r;
  logic [LVL_W-1:0]   level_r, level_nxt;
  logic [63:0]        pw_r, pw_nxt;
  logic [63:0]        comp_r, comp_nxt;
  logic               corrupt_r, corrupt_nxt;
  logic               overflow_r, overflow_nxt;
  logic [7:0]         badb_r, badb_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_r, out_nxt;

  logic               active;
  logic               is_close;
  logic               mismatch;
  logic               full;
  logic               do_push;
  logic               do_pop;
  logic               do_bad;
  logic               do_ovf;
  logic [LVL_W-1:0]   lvl_after;
  logic [63:0]        comp_after;
  logic               corrupt_after;
  logic               overflow_after;
  logic [7:0]         badb_after;
  logic [LVL_W-1:0]   rd_lvl;
  logic [ADDR_W-1:0]  rd_addr;
  entry_t             push_entry;

  function automatic logic [63:0] scale_pow(input logic [63:0] p, input logic [2:0] k);
    logic [63:0] r;
    case (k)
      CODE_PAREN:  r = p;
      CODE_SQUARE: r = {p[62:0], 1'b0};
      CODE_CURLY:  r = {p[62:0], 1'b0} + p;
      CODE_ANGLE:  r = {p[61:0], 2'b00};
      default:     r = '0;
    endcase
    return r;
  endfunction

  // Only a line-end word needs the result register free.
  assign q_take     = q_valid & (~q_item.line_end | ~out_valid_r | out_tready);
  assign out_tvalid = out_valid_r;
  assign out_result = out_r;

  always_comb begin
    active   = ~corrupt_r & ~overflow_r;
    is_close = (q_item.close_code != CODE_NONE);
    mismatch = (level_r == '0) || (top_r.code != q_item.close_code);
    full     = (level_r == LVL_W'(STACK_DEPTH));
    do_pop   = active & is_close & ~mismatch;
    do_bad   = active & is_close & mismatch;
    do_ovf   = active & ~is_close & full;
    do_push  = active & ~is_close & ~full;

    push_entry.code = q_item.open_code;
    push_entry.pow  = pw_r;

    lvl_after      = level_r;
    comp_after     = comp_r;
    corrupt_after  = corrupt_r | do_bad;
    overflow_after = overflow_r | do_ovf;
    badb_after     = do_bad ? q_item.char_byte : badb_r;
    top_nxt        = top_r;
    sec_nxt        = sec_r;
    pw_nxt         = pw_r;
    if (do_push) begin
      lvl_after  = level_r + LVL_W'(1);
      comp_after = comp_r + scale_pow(pw_r, q_item.open_code);
      top_nxt    = push_entry;
      sec_nxt    = top_r;
      pw_nxt     = {pw_r[61:0], 2'b00} + pw_r;
    end else if (do_pop) begin
      lvl_after  = level_r - LVL_W'(1);
      comp_after = comp_r - scale_pow(top_r.pow, q_item.close_code);
      top_nxt    = sec_r;
      sec_nxt    = rd_r;
      pw_nxt     = top_r.pow;
    end

    out_nxt.line_status       = ST_BALANCED;
    out_nxt.bad_byte          = '0;
    out_nxt.error_points      = '0;
    out_nxt.completion_points = '0;
    out_nxt.open_depth        = 7'(lvl_after);
    if (corrupt_after) begin
      out_nxt.line_status  = ST_CORRUPT;
      out_nxt.bad_byte     = badb_after;
      out_nxt.error_points = error_score(badb_after);
    end else if (overflow_after) begin
      out_nxt.line_status = ST_OVERFLOW;
    end else if (lvl_after != '0) begin
      out_nxt.line_status       = ST_INCOMPLETE;
      out_nxt.completion_points = comp_after;
    end

    level_nxt     = level_r;
    comp_nxt      = comp_r;
    corrupt_nxt   = corrupt_r;
    overflow_nxt  = overflow_r;
    badb_nxt      = badb_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    if (q_take) begin
      if (q_item.line_end) begin
        // line done: publish and start clean
        level_nxt     = '0;
        comp_nxt      = '0;
        pw_nxt        = 64'd1;
        corrupt_nxt   = 1'b0;
        overflow_nxt  = 1'b0;
        badb_nxt      = '0;
        out_valid_nxt = 1'b1;
      end else begin
        level_nxt    = lvl_after;
        comp_nxt     = comp_after;
        corrupt_nxt  = corrupt_after;
        overflow_nxt = overflow_after;
        badb_nxt     = badb_after;
      end
    end else begin
      top_nxt = top_r;
      sec_nxt = sec_r;
      pw_nxt  = pw_r;
    end

    // prefetch the entry that sits third from the top after this edge
    rd_lvl  = level_nxt - LVL_W'(3);
    rd_addr = rd_lvl[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      pw_r        <= 64'd1;
      comp_r      <= '0;
      corrupt_r   <= 1'b0;
      overflow_r  <= 1'b0;
      badb_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      level_r     <= level_nxt;
      pw_r        <= pw_nxt;
      comp_r      <= comp_nxt;
      corrupt_r   <= corrupt_nxt;
      overflow_r  <= overflow_nxt;
      badb_r      <= badb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    sec_r <= sec_nxt;
    if (q_take && q_item.line_end) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take && do_push) begin
      mem[level_r[ADDR_W-1:0]] <= push_entry;
    end
    rd_r <= mem[rd_addr];
  end

  `BNC_ASSERT_IMPLY(a_pow_at_empty, level_r == '0, pw_r == 64'd1, "power not one at empty stack")
  `BNC_ASSERT_NEXT(a_line_clears, q_take && q_item.line_end, level_r == '0 && !corrupt_r && !overflow_r, "state not cleared after line end")
  `BNC_ASSERT_NEXT(a_corrupt_freezes, corrupt_r && !(q_take && q_item.line_end), level_r == $past(level_r), "level moved after corruption")
  `BNC_ASSERT_IMPLY(a_corrupt_points, out_valid_r && out_r.line_status == ST_CORRUPT, out_r.error_points != '0, "corrupt line without points")
  `BNC_ASSERT_IMPLY(a_overflow_depth, out_valid_r && out_r.line_status == ST_OVERFLOW, out_r.completion_points == '0 && out_r.open_depth == 7'(STACK_DEPTH), "overflow result malformed")

endmodule

`default_nettype wire

FILE: rtl/core/bracket_nesting_checker.sv
// Channel  Dir  tdata bits                                   Side
// in_      in   [7:0] char_byte, tlast = line_end            slave
// out_     out  [1:0] line_status [9:2] bad_byte             master
//               [24:10] error_points [88:25] completion_points [95:89] open_depth
//
// Sustains one input word per cycle unless a line-end word stalls; the stack engine
// does push, pop and score update combinationally, third entry prefetched from memory.
// out_tvalid comes from a register set when the engine takes the line-end word.
// Reset clears control state only; the stack memory is not cleared.
// A two-word queue sits between byte decode and the stack engine; while a result
// waits for out_tready, words flow on and only the next line-end word stalls.
`timescale 1ns / 1ps
`default_nettype none

module bracket_nesting_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,    // [7:0] char_byte
  input  wire logic         in_tlast,    // line_end
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata    // line_status, bad_byte, error_points,
                                         // completion_points, open_depth
);
  import bnc_pkg::*;

  logic    f_push;
  item_t   f_item;
  logic    f_ready;
  logic    b_valid;
  item_t   b_item;
  logic    b_take;
  result_t b_result;

  bnc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_push    (f_push),
    .q_item    (f_item),
    .q_ready   (f_ready)
  );

  bnc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (f_push),
    .wr_item  (f_item),
    .wr_ready (f_ready),
    .rd_valid (b_valid),
    .rd_item  (b_item),
    .rd_en    (b_take)
  );

  bnc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (b_valid),
    .q_item     (b_item),
    .q_take     (b_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_result (b_result)
  );

  assign out_tdata = b_result;

endmodule

`default_nettype wire

FILE: sim/bracket_nesting_checker_tb.sv
`timescale 1ns / 1ps

module bracket_nesting_checker_tb;
  import bnc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 500;
  localparam int PHASE_WORDS = 460;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } word_t;

  typedef enum int {
    LN_BALANCED,
    LN_OPEN,
    LN_BROKEN,
    LN_NOISE,
    LN_FULL,
    LN_SPILL
  } line_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] char_byte
  logic        in_tlast = 1'b0;  // line_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;        // line_status, bad_byte, error_points,
                                 // completion_points, open_depth

  bracket_nesting_checker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Stimulus and flow control
  word_t       pending[$];
  int          send_idle_pct = 26;
  int          recv_idle_pct = 84;
  int          hold_req = 0;
  int          hold_ack;
  int          hold_left;
  int          words_sent = 0;
  int          words_queued = 0;
  int          cycles = 0;

  // Line builder scratch
  logic [7:0]  ln_body[$];
  logic [7:0]  ln_owed[$];   // closer owed per open level, 0 for a plain byte

  // Nesting predictor state
  logic [2:0]  nest_codes[STACK_DEPTH];
  logic [63:0] pow5_tab[STACK_DEPTH];
  int          nest_lvl = 0;
  logic        hit_bad = 1'b0;
  logic        hit_full = 1'b0;
  logic [7:0]  bad_char = '0;
  logic [63:0] comp_sum = '0;
  result_t     line_reports[$];

  // Checking
  result_t     got_rep;
  result_t     want_rep;
  int          fail_count = 0;
  int          by_status[4] = '{0, 0, 0, 0};

  function automatic logic [7:0] open_char(input int k);
    case (k)
      0: return CH_LPAREN;
      1: return CH_LSQUARE;
      2: return CH_LCURLY;
      default: return CH_LANGLE;
    endcase
  endfunction

  function automatic logic [7:0] close_char(input int k);
    case (k)
      0: return CH_RPAREN;
      1: return CH_RSQUARE;
      2: return CH_RCURLY;
      default: return CH_RANGLE;
    endcase
  endfunction

  function automatic bit is_bracket(input logic [7:0] b);
    return b == CH_LPAREN || b == CH_LSQUARE || b == CH_LCURLY || b == CH_LANGLE ||
           b == CH_RPAREN || b == CH_RSQUARE || b == CH_RCURLY || b == CH_RANGLE;
  endfunction

  // Advance the nesting state by one character; queue a report at line end.
  function automatic void track_char(input logic [7:0] ch, input logic eol);
    logic [2:0] want;
    logic [2:0] code;
    result_t    rep;
    if (!hit_bad && !hit_full) begin
      case (ch)
        CH_RPAREN:  want = CODE_PAREN;
        CH_RSQUARE: want = CODE_SQUARE;
        CH_RCURLY:  want = CODE_CURLY;
        CH_RANGLE:  want = CODE_ANGLE;
        default:    want = CODE_NONE;
      endcase
      if (want != CODE_NONE) begin
        if (nest_lvl == 0 || nest_codes[nest_lvl - 1] != want) begin
          hit_bad  = 1'b1;
          bad_char = ch;
        end else begin
          nest_lvl = nest_lvl - 1;
          comp_sum = comp_sum - 64'(want) * pow5_tab[nest_lvl];
        end
      end else if (nest_lvl >= STACK_DEPTH) begin
        hit_full = 1'b1;
      end else begin
        case (ch)
          CH_LPAREN:  code = CODE_PAREN;
          CH_LSQUARE: code = CODE_SQUARE;
          CH_LCURLY:  code = CODE_CURLY;
          CH_LANGLE:  code = CODE_ANGLE;
          default:    code = CODE_NONE;
        endcase
        nest_codes[nest_lvl] = code;
        comp_sum = comp_sum + 64'(code) * pow5_tab[nest_lvl];
        nest_lvl = nest_lvl + 1;
      end
    end
    if (eol) begin
      rep = '0;
      if (hit_bad) begin
        rep.line_status = ST_CORRUPT;
        rep.bad_byte    = bad_char;
        case (bad_char)
          CH_RPAREN:  rep.error_points = PTS_PAREN;
          CH_RSQUARE: rep.error_points = PTS_SQUARE;
          CH_RCURLY:  rep.error_points = PTS_CURLY;
          CH_RANGLE:  rep.error_points = PTS_ANGLE;
          default:    rep.error_points = '0;
        endcase
      end else if (hit_full) begin
        rep.line_status = ST_OVERFLOW;
      end else if (nest_lvl != 0) begin
        rep.line_status       = ST_INCOMPLETE;
        rep.completion_points = comp_sum;
      end else begin
        rep.line_status = ST_BALANCED;
      end
      rep.open_depth = 7'(nest_lvl);
      line_reports.insert(line_reports.size(), rep);
      nest_lvl = 0;
      hit_bad  = 1'b0;
      hit_full = 1'b0;
      bad_char = '0;
      comp_sum = '0;
    end
  endfunction

  task automatic flush_line();
    word_t w;
    for (int i = 0; i < ln_body.size(); i++) begin
      w.ch  = ln_body[i];
      w.eol = (i == ln_body.size() - 1);
      pending.insert(pending.size(), w);
    end
    words_queued += ln_body.size();
    ln_body.delete();
    ln_owed.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) ln_body.insert(ln_body.size(), s[i]);
    flush_line();
  endtask

  // Push one opener, or now and then a plain byte that nothing can close.
  task automatic grow_open(input bit allow_plain);
    int         k;
    logic [7:0] ch;
    k = $urandom_range(3);
    if (allow_plain && $urandom_range(7) == 0) begin
      ch = 8'($urandom_range(255));
      if (is_bracket(ch)) ch = 8'h2E;
      ln_body.insert(ln_body.size(), ch);
      ln_owed.insert(ln_owed.size(), 8'h00);
    end else begin
      ln_body.insert(ln_body.size(), open_char(k));
      ln_owed.insert(ln_owed.size(), close_char(k));
    end
  endtask

  // Emit a closer that differs from the one owed by the newest entry in ln_owed.
  task automatic bad_close();
    int         k;
    logic [7:0] top;
    logic [7:0] ch;
    k   = $urandom_range(3);
    top = (ln_owed.size() != 0) ? ln_owed[$] : 8'h00;
    ch  = close_char(k);
    if (ch == top) ch = close_char((k + 1) % 4);
    ln_body.insert(ln_body.size(), ch);
  endtask

  task automatic add_line(input line_kind_t kind, input int len);
    int cut;
    int n;
    bit early_bad;
    cut = (len > 1) ? $urandom_range(len - 1) : 0;
    case (kind)
      LN_FULL: begin
        for (int i = 0; i < STACK_DEPTH; i++) grow_open(1'b1);
        if ($urandom_range(1) && ln_owed[$] != 8'h00)
          ln_body.insert(ln_body.size(), ln_owed.pop_back());
      end
      LN_SPILL: begin
        n = STACK_DEPTH + 1 + $urandom_range(3);
        early_bad = ($urandom_range(3) == 0);
        for (int i = 0; i < n; i++) begin
          if (early_bad && i == 3) bad_close();
          else grow_open(1'b1);
        end
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) ln_body.insert(ln_body.size(), 8'($urandom_range(255)));
      end
      default: begin
        for (int i = 0; i < len; i++) begin
          if (kind == LN_NOISE || (kind == LN_BROKEN && i > cut))
            ln_body.insert(ln_body.size(), 8'($urandom_range(255)));
          else if (kind == LN_BROKEN && i == cut)
            bad_close();
          else if (ln_owed.size() != 0 && ln_owed[$] != 8'h00 && $urandom_range(1))
            ln_body.insert(ln_body.size(), ln_owed.pop_back());
          else
            grow_open(kind != LN_BALANCED);
        end
        if (kind == LN_BALANCED) begin
          while (ln_owed.size() != 0) ln_body.insert(ln_body.size(), ln_owed.pop_back());
        end else if (kind == LN_OPEN && ln_owed.size() == 0) begin
          grow_open(1'b1);
        end
      end
    endcase
    flush_line();
  endtask

  task automatic run_phase(input int s_idle, input int r_idle, input int n_words,
                           input bit long_hold);
    int         goal;
    int         r;
    int         len;
    line_kind_t kind;
    @(negedge clk);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    if (long_hold) hold_req = hold_req + 1;
    goal = words_queued + n_words;
    while (words_queued < goal) begin
      r = $urandom_range(99);
      if (r < 30)      kind = LN_BALANCED;
      else if (r < 55) kind = LN_OPEN;
      else if (r < 80) kind = LN_BROKEN;
      else if (r < 92) kind = LN_NOISE;
      else if (r < 96) kind = LN_FULL;
      else             kind = LN_SPILL;
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      add_line(kind, len);
    end
    while (pending.size() != 0) @(negedge clk);
  endtask

  // Sender: advance to the next word once the current one is taken.
  always @(posedge clk) begin : drv
    word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= w.ch;
        in_tlast  <= w.eol;
        words_sent++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_ack   <= 0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watch both channels: predict on accepted input, then check accepted results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) track_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got_rep = result_t'(out_tdata);
        if (line_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected line report: %h", out_tdata);
        end else begin
          want_rep = line_reports.pop_front();
          by_status[want_rep.line_status]++;
          if (got_rep !== want_rep) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("line report mismatch at %0t", $realtime);
              $display("  status exp %0d got %0d, bad_byte exp %h got %h",
                       want_rep.line_status, got_rep.line_status,
                       want_rep.bad_byte, got_rep.bad_byte);
              $display("  error_points exp %0d got %0d, open_depth exp %0d got %0d",
                       want_rep.error_points, got_rep.error_points,
                       want_rep.open_depth, got_rep.open_depth);
              $display("  completion exp %h got %h",
                       want_rep.completion_points, got_rep.completion_points);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles, line_reports.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    pow5_tab[0] = 64'd1;
    for (int i = 1; i < STACK_DEPTH; i++) pow5_tab[i] = pow5_tab[i - 1] * 64'd5;
    for (int i = 0; i < STACK_DEPTH; i++) nest_codes[i] = CODE_NONE;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines: every closer on an empty or wrong top, nesting of all four kinds,
    // an open line, plain-byte lines, and a plain byte inside a pair.
    add_text(")");
    add_text("(]");
    add_text("{>");
    add_text("<}");
    add_text("([{<>}])");
    add_text("<{[(");
    ln_body.insert(ln_body.size(), 8'h00);
    flush_line();
    ln_body.insert(ln_body.size(), 8'hFF);
    flush_line();
    add_text("(a)");

    run_phase(26, 84, PHASE_WORDS, 1'b1);
    run_phase(84, 26, PHASE_WORDS, 1'b1);
    run_phase(0, 0, PHASE_WORDS, 1'b0);

    while (pending.size() != 0 || in_tvalid) @(negedge clk);
    while (line_reports.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d words; checked %0d balanced, %0d incomplete, %0d corrupt, %0d overflow lines",
             words_sent, by_status[ST_BALANCED], by_status[ST_INCOMPLETE],
             by_status[ST_CORRUPT], by_status[ST_OVERFLOW]);
    $display("Bad or unexpected line reports: %0d", fail_count);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

FILE: bracket_nesting_checker.f
+incdir+rtl/core
rtl/core/bnc_pkg.sv
rtl/core/bnc_front.sv
rtl/core/bnc_queue.sv
rtl/core/bnc_back.sv
rtl/core/bracket_nesting_checker.sv
sim/bracket_nesting_checker_tb.sv
